### design/vxeh_pkg.sv
// Shared types, constants and the CRC32C byte step for the VXLAN header generator.
package vxeh_pkg;

    // Header geometry: 50 bytes leave as seven 64-bit words.
    localparam int HDR_WORDS     = 7;
    localparam int WORD_CNT_W    = 3;
    localparam logic [WORD_CNT_W-1:0] LAST_WORD_IDX = 3'd6;
    localparam logic [3:0] FULL_BYTES = 4'd8;
    localparam logic [3:0] TAIL_BYTES = 4'd2;

    // Word indexes within the header.
    localparam logic [WORD_CNT_W-1:0] W_ETH_DMAC = 3'd0;
    localparam logic [WORD_CNT_W-1:0] W_ETH_TYPE = 3'd1;
    localparam logic [WORD_CNT_W-1:0] W_IP_LEN   = 3'd2;
    localparam logic [WORD_CNT_W-1:0] W_IP_SRC   = 3'd3;
    localparam logic [WORD_CNT_W-1:0] W_UDP      = 3'd4;
    localparam logic [WORD_CNT_W-1:0] W_VXLAN    = 3'd5;
    localparam logic [WORD_CNT_W-1:0] W_VNI_LO   = 3'd6;

    // Fixed header field values.
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IPV4_VER_IHL   = 8'h45;
    localparam logic [7:0]  IPPROTO_UDP    = 8'd17;
    localparam logic [31:0] VXLAN_FLAGS    = 32'h0800_0000;
    localparam logic [15:0] IP_LEN_ADD     = 16'd36;
    localparam logic [15:0] UDP_LEN_ADD    = 16'd16;

    // CRC32C, reflected form.
    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam int MAC_BITS = 96;
    localparam int CRC_BYTES_PER_STAGE = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_SRC_IP    = 3'd0;
    localparam logic [2:0] REG_DST_IP    = 3'd1;
    localparam logic [2:0] REG_VNI       = 3'd2;
    localparam logic [2:0] REG_TUNNEL    = 3'd3;
    localparam logic [2:0] REG_TTL       = 3'd4;
    localparam logic [2:0] REG_PORT_BASE = 3'd5;
    localparam logic [2:0] REG_PORT_SPAN = 3'd6;

    // Request moving through the CRC stages.
    typedef struct packed {
        logic [95:0] macs;     // destination MAC then source MAC, wire order
        logic [15:0] len;
        logic [31:0] crc;
    } vxeh_item_t;

    // Per-request header fields that are not taken from configuration.
    typedef struct packed {
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [15:0] flow_port;
    } vxeh_hdr_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [23:0] vni;
        logic [15:0] tunnel_port;
        logic [7:0]  ttl;
        logic [15:0] port_base;
        logic [16:0] port_span;
    } vxeh_cfg_t;

    // One byte of reflected CRC32C.
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/vxeh_crc_stage.sv
// One pipeline stage that folds four MAC bytes into the running CRC32C.
module vxeh_crc_stage #(
    parameter int STAGE = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vxeh_pkg::vxeh_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vxeh_pkg::vxeh_item_t out_item
);
    import vxeh_pkg::*;

    localparam int TOP_BIT = MAC_BITS - 1 - STAGE * CRC_BYTES_PER_STAGE * 8;

    logic       valid_reg;
    vxeh_item_t item_reg;
    vxeh_item_t item_next;

    // The stage advances whenever it is empty or its request moves on.
    assign in_ready = !valid_reg || out_ready;

    // Fold this stage's bytes, earliest wire byte first.
    always_comb begin
        item_next = in_item;
        for (int b = 0; b < CRC_BYTES_PER_STAGE; b++) begin
            item_next.crc = crc32c_byte(item_next.crc, in_item.macs[TOP_BIT - 8*b -: 8]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### design/vxeh_port_scale.sv
// Two pipeline stages: scale the CRC into the port range and form the lengths.
module vxeh_port_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vxeh_pkg::vxeh_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vxeh_pkg::vxeh_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vxeh_pkg::vxeh_hdr_t  out_hdr
);
    import vxeh_pkg::*;

    logic        mul_valid_reg;
    logic [15:0] mul_hi_reg;
    logic [15:0] mul_len_reg;
    logic [48:0] product;
    logic        mul_ready;

    logic        hdr_valid_reg;
    vxeh_hdr_t   hdr_reg;
    vxeh_hdr_t   hdr_next;

    // Stage one: 32 by 17 multiply, keep the 16 bits that survive the wrap.
    assign product  = {17'd0, in_item.crc} * {32'd0, cfg.port_span};
    assign in_ready = !mul_valid_reg || mul_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (in_ready) begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            mul_hi_reg  <= product[47:32];
            mul_len_reg <= in_item.len;
        end
    end

    // Stage two: add the port base and derive both length fields, all modulo 2^16.
    assign mul_ready = !hdr_valid_reg || out_ready;

    always_comb begin
        hdr_next.flow_port = mul_hi_reg + cfg.port_base;
        hdr_next.ip_len    = mul_len_reg + IP_LEN_ADD;
        hdr_next.udp_len   = mul_len_reg + UDP_LEN_ADD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            hdr_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && mul_valid_reg) begin
            hdr_reg <= hdr_next;
        end
    end

    assign out_valid = hdr_valid_reg;
    assign out_hdr   = hdr_reg;

endmodule

### design/vxeh_serializer.sv
// Holds one finished header and sends it out as seven 64-bit words.
module vxeh_serializer (
    input  logic                aclk,
    input  logic                aresetn,
    input  vxeh_pkg::vxeh_cfg_t cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  vxeh_pkg::vxeh_hdr_t in_hdr,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [63:0]         m_header_word,
    output logic [3:0]          m_valid_bytes,
    output logic                m_last_word
);
    import vxeh_pkg::*;

    logic                  hold_reg;
    vxeh_hdr_t             hdr_reg;
    logic [WORD_CNT_W-1:0] cnt_reg;
    logic [WORD_CNT_W-1:0] cnt_next;
    logic                  at_last;
    logic                  last_taken;

    assign at_last    = (cnt_reg == LAST_WORD_IDX);
    assign last_taken = hold_reg && m_ready && at_last;

    // A new header loads while the last word of the previous one is taken.
    assign in_ready = !hold_reg || last_taken;

    always_comb begin
        cnt_next = cnt_reg;
        if (last_taken || !hold_reg) begin
            cnt_next = '0;
        end else if (m_ready) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (in_ready) begin
                hold_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            hdr_reg <= in_hdr;
        end
    end

    // Word selection; outer MACs and both checksums are zero.
    always_comb begin
        case (cnt_reg)
            W_ETH_DMAC: m_header_word = '0;
            W_ETH_TYPE: m_header_word = {32'd0, ETHERTYPE_IPV4, IPV4_VER_IHL, 8'd0};
            W_IP_LEN:   m_header_word = {hdr_reg.ip_len, 32'd0, cfg.ttl, IPPROTO_UDP};
            W_IP_SRC:   m_header_word = {16'd0, cfg.src_ip, cfg.dst_ip[31:16]};
            W_UDP:      m_header_word = {cfg.dst_ip[15:0], hdr_reg.flow_port,
                                         cfg.tunnel_port, hdr_reg.udp_len};
            W_VXLAN:    m_header_word = {16'd0, VXLAN_FLAGS, cfg.vni[23:8]};
            W_VNI_LO:   m_header_word = {cfg.vni[7:0], 56'd0};
            default:    m_header_word = '0;
        endcase
    end

    assign m_valid       = hold_reg;
    assign m_last_word   = at_last;
    assign m_valid_bytes = at_last ? TAIL_BYTES : FULL_BYTES;

    // The word counter wraps to the first word after the last one is taken.
    a_cnt_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        last_taken |=> (cnt_reg == '0))
        else $error("word counter did not wrap after the last word");

    // A stalled word keeps its place and stays offered.
    a_cnt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(cnt_reg)))
        else $error("stalled header word moved");

    // No new header may load while the current one is still being sent.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_reg && !last_taken) |-> !in_ready)
        else $error("header loaded over one in progress");

    // The counter never passes the last word.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LAST_WORD_IDX)
        else $error("word counter out of range");

endmodule

### design/vxeh_pipeline.sv
// Three CRC stages followed by the port scaling stages.
module vxeh_pipeline (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vxeh_pkg::vxeh_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vxeh_pkg::vxeh_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vxeh_pkg::vxeh_hdr_t  out_hdr
);
    import vxeh_pkg::*;

    localparam int N_CRC = MAC_BITS / (CRC_BYTES_PER_STAGE * 8);

    logic       vld [N_CRC+1];
    logic       rdy [N_CRC+1];
    vxeh_item_t itm [N_CRC+1];

    assign vld[0]   = in_valid;
    assign itm[0]   = in_item;
    assign in_ready = rdy[0];

    // CRC stages, four MAC bytes each.
    for (genvar g = 0; g < N_CRC; g++) begin : g_crc
        vxeh_crc_stage #(.STAGE(g)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_item   (itm[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_item  (itm[g+1])
        );
    end

    vxeh_port_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (vld[N_CRC]),
        .in_ready  (rdy[N_CRC]),
        .in_item   (itm[N_CRC]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_hdr   (out_hdr)
    );

endmodule

### design/vxlan_encap_header_generator.sv
// VXLAN outer header generator: takes an inner frame's MACs, ethertype and length and
// sends out the 50-byte Ethernet, IPv4, UDP and VXLAN header as seven 64-bit words,
// earliest byte in bits 63:56, with the last word carrying two bytes. The outer MACs
// and both checksums are zero. The UDP source port is a CRC32C over the inner MACs,
// seeded with the byte-swapped ethertype and scaled into base .. base+span-1. A request
// passes three CRC stages, a multiply stage and a length/port stage before the
// serializer offers its first word. Seven words per header bound the sustained rate;
// up to six requests sit in the pipeline and output buffer while the output stalls.
// The user writes configuration only while idle; the block does not enforce it.
module vxlan_encap_header_generator (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    // Request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [47:0] s_inner_dest_mac,
    input  logic [47:0] s_inner_source_mac,
    input  logic [15:0] s_inner_ethertype,
    input  logic [15:0] s_inner_length,
    // Header word channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_header_word,
    output logic [3:0]  m_valid_bytes,
    output logic        m_last_word
);
    import vxeh_pkg::*;

    vxeh_cfg_t  cfg_reg;
    vxeh_item_t in_item;
    vxeh_hdr_t  pipe_hdr;
    logic       pipe_valid;
    logic       pipe_ready;

    // Configuration registers; values are masked to their width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_ip      <= 32'h0A0A_0A0A;
            cfg_reg.dst_ip      <= 32'h0A0A_0A0B;
            cfg_reg.vni         <= 24'd1000;
            cfg_reg.tunnel_port <= 16'd4789;
            cfg_reg.ttl         <= 8'd64;
            cfg_reg.port_base   <= 16'd49152;
            cfg_reg.port_span   <= 17'd16384;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SRC_IP:    cfg_reg.src_ip      <= cfg_wr_data;
                REG_DST_IP:    cfg_reg.dst_ip      <= cfg_wr_data;
                REG_VNI:       cfg_reg.vni         <= cfg_wr_data[23:0];
                REG_TUNNEL:    cfg_reg.tunnel_port <= cfg_wr_data[15:0];
                REG_TTL:       cfg_reg.ttl         <= cfg_wr_data[7:0];
                REG_PORT_BASE: cfg_reg.port_base   <= cfg_wr_data[15:0];
                REG_PORT_SPAN: cfg_reg.port_span   <= cfg_wr_data[16:0];
                default:       ;
            endcase
        end
    end

    // The CRC starts from the ethertype with its bytes swapped.
    always_comb begin
        in_item.macs = {s_inner_dest_mac, s_inner_source_mac};
        in_item.len  = s_inner_length;
        in_item.crc  = {16'd0, s_inner_ethertype[7:0], s_inner_ethertype[15:8]};
    end

    vxeh_pipeline u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_hdr   (pipe_hdr)
    );

    vxeh_serializer u_ser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (pipe_valid),
        .in_ready      (pipe_ready),
        .in_hdr        (pipe_hdr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_header_word (m_header_word),
        .m_valid_bytes (m_valid_bytes),
        .m_last_word   (m_last_word)
    );

endmodule
